>>> hw/rtl/frw_pkg.sv
// Shared types and constants for the fragment reassembly window.
// Used by frw_seq and fragment_reassembly_window_top; no dependencies.
package frw_pkg;

	localparam int SEQ_W   = 12;
	localparam int IDX_W   = 4;
	localparam int LEN_W   = 8;
	localparam int MAP_W   = 16;
	localparam int OLEN_W  = 11;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HEAD,
		ST_DELTA,
		ST_OFF,
		ST_CHECK,
		ST_SUM,
		ST_EMIT
	} state_t;

	// operand selection of the shared 12-bit adder
	typedef enum logic [2:0] {
		ALU_HEAD,   // seq - index
		ALU_DELTA,  // seq - base
		ALU_OFF,    // head - base
		ALU_WALK,   // offset + walk counter
		ALU_ADV     // head + known count
	} alu_op_t;

	typedef struct packed {
		logic    busy;
		logic    load;
		alu_op_t op;
		logic    upd;
		logic    chk;
		logic    chk_pass;
		logic    sum;
		logic    emit;
	} ctrl_t;

	typedef struct packed {
		logic item_ok;
		logic chk_fail;
		logic walk_last;
		logic sum_last;
	} stat_t;

	// offset-to-slot table: entry i holds i mod ws, built by repeated subtraction
	function automatic logic [15:0][IDX_W-1:0] slot_table(input int ws);
		logic [15:0][IDX_W-1:0] t;
		int v;
		for (int i = 0; i < 16; i++) begin
			v = i;
			for (int k = 0; k < 16; k++) begin
				if (v >= ws)
					v = v - ws;
			end
			t[i] = IDX_W'(v);
		end
		return t;
	endfunction

endpackage

>>> hw/rtl/fragment_reassembly_window_top.sv
// Fragment reassembly window, top level: window state, shared adder and
// length RAM. Depends on frw_pkg, frw_seq and frw_ram.
//
// Usage: drive seq_number, frag_index, frag_total and frag_length and raise
// start; the header transfers on a rising edge with start high and busy low.
// A header with a bad count or index is dropped in that same cycle and
// busy never rises. A good header keeps busy high for the header, window
// and offset steps, K presence checks and K+1 length-summing steps, K
// being the known fragment count (up to 15), when the completion walk
// passes, and fewer when the walk stops at a missing slot, all through one
// 12-bit adder, plus one step that registers the result.
// The result appears in the same cycle that busy falls, marked by result_strobe
// for exactly one cycle; the receiver cannot stall, so the result must be
// taken then. Slot lengths sit in a small RAM read one slot a cycle; only
// slots marked received are ever summed, so the RAM needs no clearing.
// Reset (arst_n low) clears the window, the received mask and the count;
// the block is ready on the first cycle after reset is released.
module fragment_reassembly_window_top import frw_pkg::*; #(
	parameter int WINDOW_SLOTS     = 16,
	parameter int MAX_FRAGS        = 15,
	parameter int FRAG_BYTES_MAX   = 255,
	parameter int PACKET_BYTES_MAX = 1536
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [SEQ_W-1:0]  seq_number,
	input  logic [IDX_W-1:0]  frag_index,
	input  logic [IDX_W-1:0]  frag_total,
	input  logic [LEN_W-1:0]  frag_length,
	output logic              result_strobe,
	output logic [SEQ_W-1:0]  ack_base,
	output logic [MAP_W-1:0]  ack_bitmap,
	output logic              message_done,
	output logic [OLEN_W-1:0] message_length,
	output logic [IDX_W-1:0]  message_frags
);

	localparam int AW    = $clog2(WINDOW_SLOTS);
	localparam int SUM_W = $clog2(PACKET_BYTES_MAX + FRAG_BYTES_MAX + 1);
	localparam logic [15:0][IDX_W-1:0] SLOT_MAP = slot_table(WINDOW_SLOTS);

	ctrl_t ctrl;
	stat_t stat;

	// item registers
	logic [SEQ_W-1:0] seq_q, head_q, off_q;
	logic [IDX_W-1:0] fi_q, nf_q, j_q;
	logic [LEN_W-1:0] len_q;
	// window state
	logic [SEQ_W-1:0]        base_q;
	logic                    wvalid_q;
	logic [WINDOW_SLOTS-1:0] mask_q;
	logic [IDX_W-1:0]        kc_q;
	// walk state
	logic [SUM_W-1:0] total_q;
	logic             stop_q;
	logic             complete_q;

	// shared adder
	logic [SEQ_W-1:0] alu_a, alu_b, alu_y;
	logic             alu_cin;

	always_comb begin
		alu_a   = seq_q;
		alu_b   = ~SEQ_W'(fi_q);
		alu_cin = 1'b1;
		unique case (ctrl.op)
			ALU_HEAD: begin
				alu_a   = seq_q;
				alu_b   = ~SEQ_W'(fi_q);
				alu_cin = 1'b1;
			end
			ALU_DELTA: begin
				alu_a   = seq_q;
				alu_b   = ~base_q;
				alu_cin = 1'b1;
			end
			ALU_OFF: begin
				alu_a   = head_q;
				alu_b   = ~base_q;
				alu_cin = 1'b1;
			end
			ALU_WALK: begin
				alu_a   = off_q;
				alu_b   = SEQ_W'(j_q);
				alu_cin = 1'b0;
			end
			ALU_ADV: begin
				alu_a   = head_q;
				alu_b   = SEQ_W'(kc_q);
				alu_cin = 1'b0;
			end
			default: ;
		endcase
		alu_y = alu_a + alu_b + SEQ_W'(alu_cin);
	end

	// header check on the input ports
	assign stat.item_ok = (frag_total != '0) && (frag_total <= IDX_W'(MAX_FRAGS))
		&& (frag_index < frag_total);

	// window placement
	logic                    restart;
	logic [IDX_W-1:0]        delta4;
	logic [AW-1:0]           slot;
	logic [WINDOW_SLOTS-1:0] slot_bit;

	assign restart  = !wvalid_q || (alu_y >= SEQ_W'(WINDOW_SLOTS));
	assign delta4   = restart ? fi_q : alu_y[IDX_W-1:0];
	assign slot     = AW'(SLOT_MAP[delta4]);
	assign slot_bit = WINDOW_SLOTS'(1) << slot;

	// presence check on the walk address
	logic [(2**AW)-1:0] mask_ext;
	assign mask_ext       = (2**AW)'(mask_q);
	assign stat.chk_fail  = (alu_y >= SEQ_W'(WINDOW_SLOTS)) || !mask_ext[alu_y[AW-1:0]];
	assign stat.walk_last = (j_q == kc_q - IDX_W'(1));
	assign stat.sum_last  = (j_q == kc_q);

	// length RAM
	logic [LEN_W-1:0] rd_len;
	logic [SUM_W-1:0] sum_try;

	frw_ram #(
		.WIDTH(LEN_W),
		.DEPTH(WINDOW_SLOTS)
	) u_len_ram (
		.clk   (clk),
		.we    (ctrl.upd),
		.waddr (slot),
		.wdata (len_q),
		.raddr (alu_y[AW-1:0]),
		.rdata (rd_len)
	);

	assign sum_try = total_q + SUM_W'(rd_len);

	frw_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	assign busy = ctrl.busy;

	// per-item payload registers
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			seq_q <= seq_number;
			fi_q  <= frag_index;
			nf_q  <= frag_total;
			len_q <= (frag_length > LEN_W'(FRAG_BYTES_MAX)) ? LEN_W'(FRAG_BYTES_MAX)
				: frag_length;
		end
		if (ctrl.op == ALU_HEAD && ctrl.busy)
			head_q <= alu_y;
		if (ctrl.op == ALU_OFF)
			off_q <= alu_y;
		if (ctrl.op == ALU_OFF || ctrl.chk_pass)
			j_q <= '0;
		else if (ctrl.chk || ctrl.sum)
			j_q <= j_q + IDX_W'(1);
		if (ctrl.chk_pass) begin
			total_q <= '0;
			stop_q  <= 1'b0;
		end else if (ctrl.sum && j_q != '0 && !stop_q) begin
			// sum stops at the first length that would overflow the packet
			if (sum_try > SUM_W'(PACKET_BYTES_MAX))
				stop_q <= 1'b1;
			else
				total_q <= sum_try;
		end
	end

	// window and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q        <= '0;
			wvalid_q      <= 1'b0;
			mask_q        <= '0;
			kc_q          <= '0;
			complete_q    <= 1'b0;
			result_strobe <= 1'b0;
		end else begin
			result_strobe <= ctrl.emit;
			if (ctrl.load)
				complete_q <= 1'b0;
			else if (ctrl.chk_pass)
				complete_q <= 1'b1;
			if (ctrl.upd) begin
				if (restart) begin
					base_q   <= head_q;
					wvalid_q <= 1'b1;
					mask_q   <= slot_bit;
					kc_q     <= nf_q;
				end else begin
					mask_q <= mask_q | slot_bit;
					if (kc_q == '0 || fi_q == '0)
						kc_q <= nf_q;
				end
			end
			if (ctrl.emit && complete_q) begin
				base_q <= alu_y;
				mask_q <= '0;
				kc_q   <= '0;
			end
		end
	end

	// result registers
	always_ff @(posedge clk) begin
		if (ctrl.emit) begin
			ack_base       <= head_q;
			ack_bitmap     <= MAP_W'(mask_q);
			message_done   <= complete_q;
			message_length <= complete_q ? OLEN_W'(total_q) : '0;
			message_frags  <= complete_q ? kc_q : '0;
		end
	end

endmodule

>>> hw/rtl/frw_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module frw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

>>> hw/rtl/frw_seq.sv
// Sequencer for the fragment reassembly window: state register and
// per-state control of the shared adder. Depends on frw_pkg.
module frw_seq import frw_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  stat_t stat,
	output ctrl_t ctrl
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d       = state_q;
		ctrl          = '0;
		ctrl.op       = ALU_HEAD;
		ctrl.busy     = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				ctrl.busy = 1'b0;
				if (start) begin
					ctrl.load = 1'b1;
					if (stat.item_ok)
						state_d = ST_HEAD;
				end
			end
			ST_HEAD: begin
				ctrl.op = ALU_HEAD;
				state_d = ST_DELTA;
			end
			ST_DELTA: begin
				ctrl.op  = ALU_DELTA;
				ctrl.upd = 1'b1;
				state_d  = ST_OFF;
			end
			ST_OFF: begin
				ctrl.op = ALU_OFF;
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				ctrl.op  = ALU_WALK;
				ctrl.chk = 1'b1;
				if (stat.chk_fail)
					state_d = ST_EMIT;
				else if (stat.walk_last) begin
					ctrl.chk_pass = 1'b1;
					state_d       = ST_SUM;
				end
			end
			ST_SUM: begin
				ctrl.op  = ALU_WALK;
				ctrl.sum = 1'b1;
				if (stat.sum_last)
					state_d = ST_EMIT;
			end
			ST_EMIT: begin
				ctrl.op   = ALU_ADV;
				ctrl.emit = 1'b1;
				state_d   = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

>>> tb/fragment_reassembly_window_checker.sv
// Scoreboard for the fragment reassembly window: keeps its own copy of the window
// state, predicts each ack from the accepted headers and compares the block's acks.
// Depends on frw_pkg for the port widths.
module fragment_reassembly_window_checker import frw_pkg::*; #(
	parameter int N_SLOTS        = 16,
	parameter int FRAG_CAP       = 15,
	parameter int FRAG_BYTES_CAP = 255,
	parameter int MSG_BYTES_CAP  = 1536
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  logic [SEQ_W-1:0]  seq_number,
	input  logic [IDX_W-1:0]  frag_index,
	input  logic [IDX_W-1:0]  frag_total,
	input  logic [LEN_W-1:0]  frag_length,
	input  logic              result_strobe,
	input  logic [SEQ_W-1:0]  ack_base,
	input  logic [MAP_W-1:0]  ack_bitmap,
	input  logic              message_done,
	input  logic [OLEN_W-1:0] message_length,
	input  logic [IDX_W-1:0]  message_frags,
	output int                errors,
	output int                pending,
	output int                headers_seen,
	output int                headers_dropped,
	output int                acks_checked,
	output int                msgs_done
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [SEQ_W-1:0]  base;
		logic [MAP_W-1:0]  bitmap;
		logic              done;
		logic [OLEN_W-1:0] total;
		logic [IDX_W-1:0]  frags;
	} ack_t;

	ack_t             ack_q[$];
	logic [SEQ_W-1:0] win_base;
	logic             win_open;
	logic [MAP_W-1:0] rx_mask;
	logic [IDX_W-1:0] msg_frags;
	logic [LEN_W-1:0] frag_len[16];

	task automatic drop_window();
		rx_mask = '0;
		msg_frags = '0;
		for (int i = 0; i < 16; i++)
			frag_len[i] = '0;
	endtask

	task automatic track_header(input logic [SEQ_W-1:0] seq, input logic [IDX_W-1:0] fi,
			input logic [IDX_W-1:0] nf, input logic [LEN_W-1:0] len,
			output bit emits, output ack_t a);
		logic [SEQ_W-1:0] head, delta, off;
		int slot, j, sum, blen;
		bit whole;
		emits = 1'b0;
		a = '0;
		if (nf == 0 || nf > FRAG_CAP || fi >= nf)
			return;
		emits = 1'b1;
		head = seq - SEQ_W'(fi);
		delta = seq - win_base;
		if (!win_open || delta >= N_SLOTS) begin
			win_base = head;
			win_open = 1'b1;
			drop_window();
			delta = SEQ_W'(fi);
		end
		slot = int'(delta) % N_SLOTS;
		blen = (len > FRAG_BYTES_CAP) ? FRAG_BYTES_CAP : int'(len);
		frag_len[slot] = LEN_W'(blen);
		rx_mask[slot] = 1'b1;
		if (msg_frags == 0 || fi == 0)
			msg_frags = nf;
		if (msg_frags > FRAG_CAP)
			msg_frags = IDX_W'(FRAG_CAP);
		a.base = head;
		a.bitmap = rx_mask;
		if (msg_frags != 0) begin
			whole = 1'b1;
			for (j = 0; j < msg_frags; j++) begin
				off = head + SEQ_W'(j) - win_base;
				if (off >= N_SLOTS || !rx_mask[off[3:0]]) begin
					whole = 1'b0;
					break;
				end
			end
			if (whole) begin
				// bytes are summed in message order until the packet limit would be crossed
				sum = 0;
				for (j = 0; j < msg_frags; j++) begin
					off = head + SEQ_W'(j) - win_base;
					if (sum + frag_len[int'(off) % N_SLOTS] > MSG_BYTES_CAP)
						break;
					sum += frag_len[int'(off) % N_SLOTS];
				end
				a.done = 1'b1;
				a.total = OLEN_W'(sum);
				a.frags = msg_frags;
				win_base = head + SEQ_W'(msg_frags);
				drop_window();
			end
		end
	endtask

	always @(posedge clk) begin : watch
		bit   emits;
		ack_t want;
		if (!arst_n) begin
			ack_q.delete();
			win_base = '0;
			win_open = 1'b0;
			drop_window();
			errors = 0;
			pending = 0;
			headers_seen = 0;
			headers_dropped = 0;
			acks_checked = 0;
			msgs_done = 0;
		end else begin
			// result belongs to an earlier header, so compare before queuing the new one
			if (result_strobe) begin
				acks_checked++;
				if (ack_q.size() == 0) begin
					$error("ack with nothing expected: ack_base %0d ack_bitmap %h",
						ack_base, ack_bitmap);
					errors++;
				end else begin
					want = ack_q.pop_front();
					if (want.done)
						msgs_done++;
					if (ack_base !== want.base) begin
						$error("ack_base: expected %0d, got %0d", want.base, ack_base);
						errors++;
					end
					if (ack_bitmap !== want.bitmap) begin
						$error("ack_bitmap: expected %h, got %h", want.bitmap, ack_bitmap);
						errors++;
					end
					if (message_done !== want.done) begin
						$error("message_done: expected %0d, got %0d", want.done, message_done);
						errors++;
					end
					if (message_length !== want.total) begin
						$error("message_length: expected %0d, got %0d", want.total,
							message_length);
						errors++;
					end
					if (message_frags !== want.frags) begin
						$error("message_frags: expected %0d, got %0d", want.frags,
							message_frags);
						errors++;
					end
				end
			end
			if (start && !busy) begin
				headers_seen++;
				track_header(seq_number, frag_index, frag_total, frag_length, emits, want);
				if (emits)
					ack_q.push_back(want);
				else
					headers_dropped++;
			end
			pending = ack_q.size();
		end
	end

endmodule

>>> tb/fragment_reassembly_window_top_tb.sv
// Stimulus and verdict for the fragment reassembly window: drives fragment headers
// through the start/busy transfer and relies on fragment_reassembly_window_checker.
// Depends on frw_pkg and the fragment_reassembly_window_top RTL.
module fragment_reassembly_window_top_tb import frw_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS       = 16;
	localparam int FRAGS       = 15;
	localparam int FRAG_BYTES  = 255;
	localparam int PKT_BYTES   = 1536;
	localparam int BATCH       = 215;
	localparam int STALL_LIMIT = 4000;
	localparam int TAIL_CYCLES = 48;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	logic [SEQ_W-1:0]  seq_number = '0;
	logic [IDX_W-1:0]  frag_index = '0;
	logic [IDX_W-1:0]  frag_total = '0;
	logic [LEN_W-1:0]  frag_length = '0;
	logic              result_strobe;
	logic [SEQ_W-1:0]  ack_base;
	logic [MAP_W-1:0]  ack_bitmap;
	logic              message_done;
	logic [OLEN_W-1:0] message_length;
	logic [IDX_W-1:0]  message_frags;

	int errors, pending, headers_seen, headers_dropped, acks_checked, msgs_done;
	int idle_pct;
	int good_sent;
	int quiet = 0;
	logic [SEQ_W-1:0] next_head;

	always #2 clk = ~clk;

	fragment_reassembly_window_top #(
		.WINDOW_SLOTS    (SLOTS),
		.MAX_FRAGS       (FRAGS),
		.FRAG_BYTES_MAX  (FRAG_BYTES),
		.PACKET_BYTES_MAX(PKT_BYTES)
	) DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.seq_number    (seq_number),
		.frag_index    (frag_index),
		.frag_total    (frag_total),
		.frag_length   (frag_length),
		.result_strobe (result_strobe),
		.ack_base      (ack_base),
		.ack_bitmap    (ack_bitmap),
		.message_done  (message_done),
		.message_length(message_length),
		.message_frags (message_frags)
	);

	fragment_reassembly_window_checker #(
		.N_SLOTS       (SLOTS),
		.FRAG_CAP      (FRAGS),
		.FRAG_BYTES_CAP(FRAG_BYTES),
		.MSG_BYTES_CAP (PKT_BYTES)
	) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.seq_number     (seq_number),
		.frag_index     (frag_index),
		.frag_total     (frag_total),
		.frag_length    (frag_length),
		.result_strobe  (result_strobe),
		.ack_base       (ack_base),
		.ack_bitmap     (ack_bitmap),
		.message_done   (message_done),
		.message_length (message_length),
		.message_frags  (message_frags),
		.errors         (errors),
		.pending        (pending),
		.headers_seen   (headers_seen),
		.headers_dropped(headers_dropped),
		.acks_checked   (acks_checked),
		.msgs_done      (msgs_done)
	);

	// watchdog: any cycle with a header or an ack transfer counts as progress
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || result_strobe)
				quiet = 0;
			else
				quiet++;
			if (quiet >= STALL_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	function automatic logic [LEN_W-1:0] pick_len(input bit hot);
		return hot ? LEN_W'($urandom_range(180, 255)) : LEN_W'($urandom_range(255));
	endfunction

	// called at a falling edge; returns at the falling edge after the transfer
	task automatic push_header(input logic [SEQ_W-1:0] s, input logic [IDX_W-1:0] fi,
			input logic [IDX_W-1:0] nf, input logic [LEN_W-1:0] ln);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < idle_pct);
		end
		start <= 1'b1;
		seq_number <= s;
		frag_index <= fi;
		frag_total <= nf;
		frag_length <= ln;
		do @(posedge clk); while (busy);
		@(negedge clk);
		if (nf != 0 && fi < nf)
			good_sent++;
	endtask

	// one message in shuffled order, now and then with a lost or repeated fragment
	task automatic send_message(input logic [SEQ_W-1:0] head, input int nfrag, input bit hot);
		int order[16];
		int k, t, tmp, skip, extra;
		logic [SEQ_W-1:0] s;
		logic [LEN_W-1:0] ln;
		for (k = 0; k < nfrag; k++)
			order[k] = k;
		for (k = nfrag - 1; k > 0; k--) begin
			t = $urandom_range(k);
			tmp = order[k];
			order[k] = order[t];
			order[t] = tmp;
		end
		skip = ($urandom_range(9) == 0) ? $urandom_range(nfrag - 1) : -1;
		extra = ($urandom_range(9) == 0) ? $urandom_range(nfrag - 1) : -1;
		for (k = 0; k < nfrag; k++) begin
			if (k == skip)
				continue;
			s = head + SEQ_W'(order[k]);
			ln = pick_len(hot);
			push_header(s, IDX_W'(order[k]), IDX_W'(nfrag), ln);
			if (k == extra)
				push_header(s, IDX_W'(order[k]), IDX_W'(nfrag), ln);
		end
	endtask

	initial begin
		int ph, goal, roll, nfrag, k;
		logic [SEQ_W-1:0] head;
		good_sent = 0;
		idle_pct = 15;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// malformed headers: zero count, index equal to count, index 15 of 15
		push_header(12'd7, 4'd0, 4'd0, 8'd9);
		push_header(12'd7, 4'd5, 4'd5, 8'd9);
		push_header(12'd7, 4'd15, 4'd15, 8'd9);
		// single fragment with no payload
		push_header(12'd0, 4'd0, 4'd1, 8'd0);
		// head sequence wraps below zero, tail arrives first
		push_header(12'd0, 4'd1, 4'd2, 8'd255);
		push_header(12'hFFF, 4'd0, 4'd2, 8'd255);
		// partial message abandoned by a restart far outside the window
		push_header(12'd2000, 4'd3, 4'd4, 8'd100);
		push_header(12'd100, 4'd0, 4'd2, 8'd50);
		push_header(12'd101, 4'd1, 4'd2, 8'd60);
		// fifteen full fragments, reverse order: the sum hits the packet limit
		for (k = 14; k >= 0; k--)
			push_header(12'd4090 + SEQ_W'(k), IDX_W'(k), 4'd15, 8'd255);
		next_head = 12'd4090 + 12'd15;

		for (ph = 0; ph < 3; ph++) begin
			idle_pct = (ph == 0) ? 15 : (ph == 1) ? 88 : 0;
			goal = good_sent + BATCH;
			while (good_sent < goal) begin
				roll = $urandom_range(99);
				if (roll < 12) begin
					push_header(SEQ_W'($urandom_range(4095)), IDX_W'($urandom_range(15)),
						IDX_W'($urandom_range(15)), LEN_W'($urandom_range(255)));
				end else begin
					head = (roll < 18) ? SEQ_W'($urandom_range(4095)) : next_head;
					nfrag = ($urandom_range(3) == 0) ? $urandom_range(1, 15)
						: $urandom_range(1, 5);
					send_message(head, nfrag, $urandom_range(4) == 0);
					next_head = head + SEQ_W'(nfrag);
				end
			end
		end
		start <= 1'b0;

		while (pending != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("Run: %0d fragment headers in three idle phases (15%%, 88%%, none), %0d malformed",
			headers_seen, headers_dropped);
		$display("Run: %0d acks compared, %0d completed messages, %0d mismatches",
			acks_checked, msgs_done, errors);
		if (errors == 0 && pending == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
